// File: sv/wasb_pkg.sv
// Shared types, codes and helpers of the acknowledgement status scoreboard.
package wasb_pkg;

  localparam int unsigned DefEntries   = 64;
  localparam int unsigned DefBaWindow  = 64;
  localparam int unsigned DefFragments = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned TagW         = 21;

  typedef enum logic [3:0] {
    CMD_SENT     = 4'd0,
    CMD_ACK      = 4'd1,
    CMD_FAILED   = 4'd2,
    CMD_BAR_SENT = 4'd3,
    CMD_BLOCK_ACK = 4'd4,
    CMD_ELIGIBLE = 4'd5,
    CMD_OUTSTAND = 4'd6,
    CMD_REQUEUE  = 4'd7,
    CMD_COUNT    = 4'd8
  } cmd_e;

  localparam logic [3:0] ST_UNTX      = 4'd0;
  localparam logic [3:0] ST_NOACK     = 4'd1;
  localparam logic [3:0] ST_BA_UNREQ  = 4'd2;
  localparam logic [3:0] ST_WAIT_ACK  = 4'd3;
  localparam logic [3:0] ST_ACK_MISS  = 4'd4;
  localparam logic [3:0] ST_BA_UNACK  = 4'd5;
  localparam logic [3:0] ST_BA_ACKED  = 4'd6;
  localparam logic [3:0] ST_WAIT_BA   = 4'd7;
  localparam logic [3:0] ST_ACKED     = 4'd8;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_ACK_UNTX  = 3'd1;
  localparam logic [2:0] ERR_FULL      = 3'd2;
  localparam logic [2:0] ERR_POLICY    = 3'd3;
  localparam logic [2:0] ERR_FAIL_UNEX = 3'd4;
  localparam logic [2:0] ERR_REQ_PEND  = 3'd5;

  localparam logic [1:0] POL_NORMAL = 2'd0;
  localparam logic [1:0] POL_BLOCK  = 2'd1;
  localparam logic [1:0] POL_NOACK  = 2'd2;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_APPLY,
    ENG_EMIT,
    ENG_REPORT
  } eng_state_e;

  typedef struct packed {
    logic [3:0]  command;
    logic        is_qos;
    logic [47:0] address;
    logic [3:0]  tid;
    logic [11:0] seq_num;
    logic [3:0]  frag_num;
    logic [1:0]  ack_policy;
    logic        compressed;
    logic [63:0] bitmap;
    logic [5:0]  bitmap_offset;
    logic [3:0]  query_status;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        eligible;
    logic        outstanding;
    logic [6:0]  count;
    logic        acked_valid;
    logic [11:0] acked_seq;
    logic [3:0]  acked_frag;
    logic [2:0]  error;
    logic        last;
  } res_item_t;

  // Classified command handed from the front to the engine.
  typedef struct packed {
    logic [3:0]      command;
    logic [47:0]     address;
    logic [TagW-1:0] key;
    logic [3:0]      tid;
    logic [11:0]     seq;
    logic            compressed;
    logic [63:0]     bitmap;
    logic [5:0]      bitmap_offset;
    logic [3:0]      query_status;
    logic [3:0]      send_status;
    logic            send_bad;
  } job_t;

  typedef struct packed {
    logic [47:0]     address;
    logic [TagW-1:0] tag;
    logic [3:0]      status;
  } entry_t;

  function automatic res_item_t mk_res(logic [3:0] st, logic [6:0] cnt, logic av,
                                       logic [11:0] aseq, logic [3:0] afrag,
                                       logic [2:0] err, logic lst);
    res_item_t r;
    r.status      = st;
    r.eligible    = (st == ST_UNTX) || (st == ST_ACK_MISS) || (st == ST_BA_UNACK);
    r.outstanding = (st == ST_BA_UNREQ);
    r.count       = cnt;
    r.acked_valid = av;
    r.acked_seq   = aseq;
    r.acked_frag  = afrag;
    r.error       = err;
    r.last        = lst;
    return r;
  endfunction

endpackage

// File: sv/wlan_ack_status_scoreboard.sv
// Top level of the transmit acknowledgement status scoreboard.
//
// This block keeps the acknowledgement state of every frame a transmitter has
// sent, one table entry per key of receiver address, QoS flag, TID, sequence
// number and fragment number; a key without an entry reads as untransmitted.
// Command items enter through a queue-style port (push/full) and results leave
// through another (empty/pop). In the engine each command is taken, then
// walks the whole entry table once through its single registered read port,
// one entry per cycle; the read pipeline drains, the update is applied and
// the result is reported. A block ack that acknowledges frames replaces the
// report step with a pass over each sequence offset or fragment up to the
// last acknowledged one, and gives one item per acknowledged frame, in order
// of offset or fragment. A command queue in front of the engine and a result
// queue behind it let the producer and consumer stall independently of the
// table walk; a full result queue holds the engine in its reporting cycles.
// Every other command gives exactly one result item, and the final item of
// each command has last set. No clearing pass is needed after reset: entry
// valid bits are cleared at once.
module wlan_ack_status_scoreboard
  import wasb_pkg::*;
#(
  parameter int unsigned ENTRIES   = DefEntries,
  parameter int unsigned BA_WINDOW = DefBaWindow,
  parameter int unsigned FRAGMENTS = DefFragments
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_i,
  output logic      empty,
  input  logic      pop,
  output res_item_t res_o
);

  job_t      job;
  logic      job_empty, job_pop;
  logic      res_full, res_push;
  res_item_t res_item;

  // Classification and the command queue.
  wasb_front u_front (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_i),
    .job_pop_i   (job_pop),
    .job_empty_o (job_empty),
    .job_o       (job)
  );

  // Table walk, updates and result generation.
  wasb_engine #(
    .ENTRIES   (ENTRIES),
    .BA_WINDOW (BA_WINDOW),
    .FRAGMENTS (FRAGMENTS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .job_empty_i (job_empty),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  // Result queue towards the consumer.
  wasb_fifo #(.T(res_item_t), .DEPTH(QueueDepth)) u_res_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_item),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_o)
  );

endmodule

// File: sv/wasb_fifo.sv
// Small first-in first-out queue used between the stages of the scoreboard.
module wasb_fifo
  import wasb_pkg::*;
#(
  parameter type T = logic,
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  T     data_i,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                store_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: sv/wasb_front.sv
// Front end: accepts command items, builds the lookup key and queues them.
module wasb_front
  import wasb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t item_i,
  input  logic     job_pop_i,
  output logic     job_empty_o,
  output job_t     job_o
);

  job_t job_d;

  always_comb begin
    job_d               = '0;
    job_d.command       = item_i.command;
    job_d.address       = item_i.address;
    job_d.key           = {item_i.is_qos, item_i.is_qos ? item_i.tid : 4'd0,
                           item_i.seq_num, item_i.frag_num};
    job_d.tid           = item_i.tid;
    job_d.seq           = item_i.seq_num;
    job_d.compressed    = item_i.compressed;
    job_d.bitmap        = item_i.bitmap;
    job_d.bitmap_offset = item_i.bitmap_offset;
    job_d.query_status  = item_i.query_status;
    job_d.send_status   = ST_WAIT_ACK;
    job_d.send_bad      = 1'b0;
    // Non-QoS frames always expect a normal ack.
    if (item_i.is_qos) begin
      case (item_i.ack_policy)
        POL_NORMAL: job_d.send_status = ST_WAIT_ACK;
        POL_BLOCK:  job_d.send_status = ST_BA_UNREQ;
        POL_NOACK:  job_d.send_status = ST_NOACK;
        default:    job_d.send_bad    = 1'b1;
      endcase
    end
  end

  wasb_fifo #(.T(job_t), .DEPTH(QueueDepth)) u_job_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push_i),
    .full_o  (full_o),
    .data_i  (job_d),
    .pop_i   (job_pop_i),
    .empty_o (job_empty_o),
    .data_o  (job_o)
  );

endmodule

// File: sv/wasb_engine.sv
// Back end: scans the entry table for each command and produces its results.
module wasb_engine
  import wasb_pkg::*;
#(
  parameter int unsigned ENTRIES   = DefEntries,
  parameter int unsigned BA_WINDOW = DefBaWindow,
  parameter int unsigned FRAGMENTS = DefFragments
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_empty_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output res_item_t res_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  eng_state_e      state_q, state_d;
  job_t            job_q, job_d;
  entry_t          mem_q [ENTRIES];
  entry_t          rdata_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IW:0]     rd_cnt_q, rd_cnt_d;
  logic            pipe_vld_q, pipe_vld_d;
  logic [IW-1:0]   pipe_idx_q, pipe_idx_d;
  logic            hit_q, hit_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d;
  logic [3:0]      hit_st_q, hit_st_d;
  logic            free_q, free_d;
  logic [IW-1:0]   free_idx_q, free_idx_d;
  logic [6:0]      cnt_q, cnt_d;
  logic [63:0]     mask_q, mask_d;
  logic [5:0]      emit_q, emit_d;
  logic [3:0]      res_st_q, res_st_d;
  logic [2:0]      err_q, err_d;

  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;
  logic [IW-1:0]   raddr;
  logic            scan_done;

  // Fields of the entry under comparison.
  logic            ev, addr_eq, e_qos;
  logic [3:0]      e_tid, e_frag, ns;
  logic [11:0]     e_seq, off;
  logic [5:0]      bsel;
  logic            ba_hit;
  logic [63:0]     mask_left;

  assign raddr     = rd_cnt_q[IW-1:0];
  assign scan_done = (rd_cnt_q == (IW+1)'(ENTRIES)) && !pipe_vld_q;
  assign mask_left = mask_q & ~(64'd1 << emit_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE:   if (!job_empty_i) state_d = ENG_SCAN;
      ENG_SCAN:   if (scan_done) state_d = ENG_APPLY;
      ENG_APPLY:  begin
        if (job_q.command == CMD_BLOCK_ACK && mask_q != '0) state_d = ENG_EMIT;
        else state_d = ENG_REPORT;
      end
      ENG_EMIT:   begin
        if (!mask_q[emit_q] || !res_full_i) begin
          if (mask_left == '0) state_d = ENG_IDLE;
        end
      end
      ENG_REPORT: if (!res_full_i) state_d = ENG_IDLE;
      default:    state_d = ENG_IDLE;
    endcase
  end

  always_comb begin
    ev      = valid_q[pipe_idx_q];
    addr_eq = rdata_q.address == job_q.address;
    e_qos   = rdata_q.tag[20];
    e_tid   = rdata_q.tag[19:16];
    e_seq   = rdata_q.tag[15:4];
    e_frag  = rdata_q.tag[3:0];
    off     = e_seq - job_q.seq;
    bsel    = 6'd0;
    ba_hit  = 1'b0;
    if (job_q.compressed) begin
      bsel   = off[5:0];
      ba_hit = (e_frag == 4'd0) && (off < 12'(BA_WINDOW));
    end else begin
      bsel   = {2'b00, e_frag};
      ba_hit = ({1'b0, job_q.bitmap_offset} < 7'(BA_WINDOW))
               && (off == {6'd0, job_q.bitmap_offset})
               && ({1'b0, e_frag} < 5'(FRAGMENTS));
    end
  end

  always_comb begin
    job_d      = job_q;
    job_pop_o  = 1'b0;
    rd_cnt_d   = rd_cnt_q;
    pipe_vld_d = 1'b0;
    pipe_idx_d = raddr;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_st_d   = hit_st_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    emit_d     = emit_q;
    res_st_d   = res_st_q;
    err_d      = err_q;
    valid_d    = valid_q;
    ns         = rdata_q.status;
    we         = 1'b0;
    waddr      = pipe_idx_q;
    wdata      = rdata_q;
    res_push_o = 1'b0;
    res_o      = mk_res(res_st_q, (job_q.command == CMD_COUNT) ? cnt_q : 7'd0,
                        1'b0, 12'd0, 4'd0, err_q, 1'b1);

    case (state_q)
      ENG_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          rd_cnt_d  = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          cnt_d     = '0;
          mask_d    = '0;
          emit_d    = '0;
        end
      end
      ENG_SCAN: begin
        if (rd_cnt_q != (IW+1)'(ENTRIES)) begin
          rd_cnt_d   = rd_cnt_q + (IW+1)'(1);
          pipe_vld_d = 1'b1;
        end
        if (pipe_vld_q) begin
          if (!ev && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = pipe_idx_q;
          end
          if (ev && addr_eq) begin
            if (job_q.command == CMD_BAR_SENT && e_qos && e_tid == job_q.tid
                && rdata_q.status == ST_BA_UNREQ && !off[11]
                && !(job_q.compressed && e_frag != 4'd0)) begin
              ns = ST_WAIT_BA;
              we = 1'b1;
            end
            if (job_q.command == CMD_BLOCK_ACK && e_qos && e_tid == job_q.tid
                && rdata_q.status == ST_WAIT_BA && ba_hit) begin
              we = 1'b1;
              if (job_q.bitmap[bsel]) begin
                ns           = ST_BA_ACKED;
                mask_d[bsel] = 1'b1;
              end else begin
                ns = ST_BA_UNACK;
              end
            end
          end
          wdata.status = ns;
          if (job_q.command == CMD_COUNT && ev && e_qos
              && rdata_q.status == job_q.query_status && cnt_q != 7'd127) begin
            cnt_d = cnt_q + 7'd1;
          end
          if (ev && addr_eq && rdata_q.tag == job_q.key) begin
            hit_d     = 1'b1;
            hit_idx_d = pipe_idx_q;
            hit_st_d  = ns;
          end
        end
      end
      ENG_APPLY: begin
        err_d    = ERR_OK;
        res_st_d = hit_q ? hit_st_q : ST_UNTX;
        waddr    = hit_idx_q;
        wdata    = '{address: job_q.address, tag: job_q.key, status: hit_st_q};
        case (job_q.command)
          CMD_SENT: begin
            if (job_q.send_bad) begin
              err_d = ERR_POLICY;
            end else if (!hit_q && !free_q) begin
              err_d = ERR_FULL;
            end else begin
              we           = 1'b1;
              waddr        = hit_q ? hit_idx_q : free_idx_q;
              wdata.status = job_q.send_status;
              valid_d[waddr] = 1'b1;
              res_st_d     = job_q.send_status;
            end
          end
          CMD_ACK: begin
            if (!hit_q) begin
              err_d = ERR_ACK_UNTX;
            end else begin
              we           = 1'b1;
              wdata.status = ST_ACKED;
              res_st_d     = ST_ACKED;
            end
          end
          CMD_FAILED: begin
            if (!hit_q || hit_st_q != ST_WAIT_ACK) begin
              err_d = ERR_FAIL_UNEX;
            end else begin
              we           = 1'b1;
              wdata.status = ST_ACK_MISS;
              res_st_d     = ST_ACK_MISS;
            end
          end
          CMD_REQUEUE: begin
            if (hit_q && (hit_st_q == ST_BA_UNREQ || hit_st_q == ST_WAIT_ACK
                          || hit_st_q == ST_WAIT_BA)) begin
              err_d = ERR_REQ_PEND;
            end else begin
              if (hit_q) valid_d[hit_idx_q] = 1'b0;
              res_st_d = ST_UNTX;
            end
          end
          default: ;
        endcase
      end
      ENG_EMIT: begin
        if (mask_q[emit_q]) begin
          res_push_o = 1'b1;
          res_o = mk_res(ST_BA_ACKED, 7'd0, 1'b1,
                         job_q.compressed ? job_q.seq + {6'd0, emit_q}
                                          : job_q.seq + {6'd0, job_q.bitmap_offset},
                         job_q.compressed ? 4'd0 : emit_q[3:0],
                         ERR_OK, mask_left == '0);
          if (!res_full_i) begin
            mask_d = mask_left;
            emit_d = emit_q + 6'd1;
          end
        end else begin
          emit_d = emit_q + 6'd1;
        end
      end
      ENG_REPORT: res_push_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ENG_IDLE;
      valid_q    <= '0;
      rd_cnt_q   <= '0;
      pipe_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      rd_cnt_q   <= rd_cnt_d;
      pipe_vld_q <= pipe_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    pipe_idx_q <= pipe_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_st_q   <= hit_st_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    cnt_q      <= cnt_d;
    mask_q     <= mask_d;
    emit_q     <= emit_d;
    res_st_q   <= res_st_d;
    err_q      <= err_d;
  end

endmodule
